/* design/timestamp_text_to_epoch_ms_macros.svh */
// Assertion macros used by the checker file tte_checker.sv.
`ifndef TIMESTAMP_TEXT_TO_EPOCH_MS_MACROS_SVH
`define TIMESTAMP_TEXT_TO_EPOCH_MS_MACROS_SVH
// same-cycle implication
`define TTE_ASSERT_NOW(lbl, rst, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (rst) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define TTE_ASSERT_NEXT(lbl, rst, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (rst) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* design/tte_pkg.sv */
// Types, status codes and calendar tables for the timestamp parser.
`default_nettype none
package tte_pkg;
    localparam logic [3:0] ST_OK      = 4'd0;
    localparam logic [3:0] ST_SYNTAX  = 4'd1;
    localparam logic [3:0] ST_MONTH   = 4'd2;
    localparam logic [3:0] ST_DAY     = 4'd3;
    localparam logic [3:0] ST_HOUR    = 4'd4;
    localparam logic [3:0] ST_MINUTE  = 4'd5;
    localparam logic [3:0] ST_SECOND  = 4'd6;
    localparam logic [3:0] ST_OFFHOUR = 4'd7;
    localparam logic [3:0] ST_OFFMIN  = 4'd8;

    typedef struct packed {
        logic       ld_year;
        logic       ld_month;
        logic       ld_day;
        logic       ld_hour;
        logic       ld_min;
        logic       ld_sec;
        logic       ld_offh;
        logic       ld_offm;
        logic       ld_frac;
        logic       first_digit;
        logic       set_plus;
        logic       set_minus;
        logic [3:0] digit;
        logic       parse_ok;
        logic       calc1;
        logic       calc2;
        logic       calc3;
        logic       out_load;
    } tte_cmd_t;

    typedef struct packed {
        logic out_free;
    } tte_stat_t;

    function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
        logic [4:0] d;
        case (m)
            4'd2:                      d = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
            default:                   d = 5'd31;
        endcase
        return d;
    endfunction

    // day of a March-based year at which month m starts
    function automatic logic [8:0] month_start(input logic [3:0] m);
        logic [8:0] d;
        case (m)
            4'd3:    d = 9'd0;
            4'd4:    d = 9'd31;
            4'd5:    d = 9'd61;
            4'd6:    d = 9'd92;
            4'd7:    d = 9'd122;
            4'd8:    d = 9'd153;
            4'd9:    d = 9'd184;
            4'd10:   d = 9'd214;
            4'd11:   d = 9'd245;
            4'd12:   d = 9'd275;
            4'd1:    d = 9'd306;
            4'd2:    d = 9'd337;
            default: d = 9'd0;
        endcase
        return d;
    endfunction
endpackage
`default_nettype wire

/* design/tte_ctrl.sv */
// Parse and sequencing state machine of the timestamp parser.
`default_nettype none
module tte_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [7:0]         s_tdata,
    input  wire logic               s_tlast,
    output tte_pkg::tte_cmd_t       cmd,
    input  wire tte_pkg::tte_stat_t stat
);
    typedef enum logic [21:0] {
        PH_YEAR     = 22'd1 << 0,
        PH_AFT_YEAR = 22'd1 << 1,
        PH_MONTH    = 22'd1 << 2,
        PH_AFT_MON  = 22'd1 << 3,
        PH_DAY      = 22'd1 << 4,
        PH_AFT_DAY  = 22'd1 << 5,
        PH_HOUR     = 22'd1 << 6,
        PH_AFT_HOUR = 22'd1 << 7,
        PH_MIN      = 22'd1 << 8,
        PH_AFT_MIN  = 22'd1 << 9,
        PH_SEC      = 22'd1 << 10,
        PH_AFT_SEC  = 22'd1 << 11,
        PH_FRAC1    = 22'd1 << 12,
        PH_FRAC     = 22'd1 << 13,
        PH_OFFH     = 22'd1 << 14,
        PH_OFFCOLON = 22'd1 << 15,
        PH_OFFM     = 22'd1 << 16,
        PH_END      = 22'd1 << 17,
        CALC1       = 22'd1 << 18,
        CALC2       = 22'd1 << 19,
        CALC3       = 22'd1 << 20,
        CALC4       = 22'd1 << 21
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] dc_reg, dc_next;
    logic       syn_reg, syn_next;
    logic       ok_reg, ok_next;
    logic       accept, dig, ok, in_calc;
    logic [2:0] dc_inc;
    logic [7:0] c;

    assign c       = s_tdata;
    assign in_calc = (state_reg == CALC1) || (state_reg == CALC2) ||
                     (state_reg == CALC3) || (state_reg == CALC4);
    assign s_tready = !in_calc;
    assign accept   = s_tvalid && s_tready;
    assign dig      = (c >= 8'h30) && (c <= 8'h39);
    assign dc_inc   = dc_reg + 3'd1;

    always_comb begin
        state_next = state_reg;
        dc_next    = dc_reg;
        syn_next   = syn_reg;
        ok_next    = ok_reg;
        ok         = 1'b1;
        cmd        = '0;
        cmd.digit       = 4'(c - 8'h30);
        cmd.first_digit = (dc_reg == 3'd0);
        cmd.parse_ok    = ok_reg;
        if (accept && !syn_reg) begin
            case (state_reg)
                PH_YEAR, PH_MONTH, PH_DAY, PH_HOUR, PH_MIN, PH_SEC, PH_OFFH, PH_OFFM: begin
                    if (!dig) begin
                        ok = 1'b0;
                    end else begin
                        cmd.ld_year  = (state_reg == PH_YEAR);
                        cmd.ld_month = (state_reg == PH_MONTH);
                        cmd.ld_day   = (state_reg == PH_DAY);
                        cmd.ld_hour  = (state_reg == PH_HOUR);
                        cmd.ld_min   = (state_reg == PH_MIN);
                        cmd.ld_sec   = (state_reg == PH_SEC);
                        cmd.ld_offh  = (state_reg == PH_OFFH);
                        cmd.ld_offm  = (state_reg == PH_OFFM);
                        dc_next = dc_inc;
                        if (state_reg == PH_YEAR ? dc_inc >= 3'd4 : dc_inc >= 3'd2) begin
                            dc_next = 3'd0;
                            case (state_reg)
                                PH_YEAR:  state_next = PH_AFT_YEAR;
                                PH_MONTH: state_next = PH_AFT_MON;
                                PH_DAY:   state_next = PH_AFT_DAY;
                                PH_HOUR:  state_next = PH_AFT_HOUR;
                                PH_MIN:   state_next = PH_AFT_MIN;
                                PH_SEC:   state_next = PH_AFT_SEC;
                                PH_OFFH:  state_next = PH_OFFCOLON;
                                default:  state_next = PH_END;
                            endcase
                        end
                    end
                end
                PH_OFFCOLON: begin
                    if (c == ":") begin
                        state_next = PH_OFFM;
                        dc_next    = 3'd0;
                    end else begin
                        ok = 1'b0;
                    end
                end
                PH_AFT_YEAR, PH_AFT_MON, PH_AFT_DAY, PH_AFT_HOUR, PH_AFT_MIN, PH_AFT_SEC,
                PH_FRAC1, PH_FRAC: begin
                    if ((state_reg == PH_AFT_YEAR || state_reg == PH_AFT_MON) && c == "-") begin
                        state_next = (state_reg == PH_AFT_YEAR) ? PH_MONTH : PH_DAY;
                        dc_next    = 3'd0;
                    end else if (state_reg == PH_AFT_DAY && c == "T") begin
                        state_next = PH_HOUR;
                        dc_next    = 3'd0;
                    end else if ((state_reg == PH_AFT_HOUR || state_reg == PH_AFT_MIN) &&
                                 c == ":") begin
                        state_next = (state_reg == PH_AFT_HOUR) ? PH_MIN : PH_SEC;
                        dc_next    = 3'd0;
                    end else if (state_reg == PH_AFT_SEC && c == ".") begin
                        state_next = PH_FRAC1;
                    end else if ((state_reg == PH_FRAC1 || state_reg == PH_FRAC) && dig) begin
                        cmd.ld_frac = 1'b1;
                        state_next  = PH_FRAC;
                    end else if (state_reg == PH_FRAC1) begin
                        ok = 1'b0;
                    end else if (c == "Z") begin
                        state_next = PH_END;
                    end else if (c == "+" || c == "-") begin
                        cmd.set_plus  = (c == "+");
                        cmd.set_minus = (c == "-");
                        state_next    = PH_OFFH;
                        dc_next       = 3'd0;
                    end else begin
                        ok = 1'b0;
                    end
                end
                default: ok = 1'b0;
            endcase
            syn_next = !ok;
        end
        if (accept && s_tlast) begin
            ok_next = !syn_next &&
                      ((state_next == PH_AFT_YEAR) || (state_next == PH_AFT_MON) ||
                       (state_next == PH_AFT_DAY) || (state_next == PH_AFT_HOUR) ||
                       (state_next == PH_AFT_MIN) || (state_next == PH_AFT_SEC) ||
                       (state_next == PH_FRAC) || (state_next == PH_END));
            state_next = CALC1;
        end
        case (state_reg)
            CALC1: begin
                cmd.calc1  = 1'b1;
                state_next = CALC2;
                dc_next    = 3'd0;
                syn_next   = 1'b0;
            end
            CALC2: begin
                cmd.calc2  = 1'b1;
                state_next = CALC3;
            end
            CALC3: begin
                cmd.calc3  = 1'b1;
                state_next = CALC4;
            end
            CALC4: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = PH_YEAR;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= PH_YEAR;
            dc_reg    <= 3'd0;
            syn_reg   <= 1'b0;
            ok_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            dc_reg    <= dc_next;
            syn_reg   <= syn_next;
            ok_reg    <= ok_next;
        end
    end
endmodule
`default_nettype wire

/* design/tte_dpath.sv */
// Field accumulators, range checks and epoch arithmetic of the timestamp parser.
`default_nettype none
module tte_dpath (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire tte_pkg::tte_cmd_t cmd,
    output tte_pkg::tte_stat_t     stat,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [55:0]            m_tdata
);
    logic [13:0] year_reg;
    logic [6:0]  month_reg, day_reg, hour_reg, min_reg, sec_reg, offh_reg, offm_reg;
    logic [9:0]  millis_reg;
    logic [1:0]  fd_reg, sign_reg, sgn_s_reg;

    logic [3:0]  status_reg;
    logic [21:0] y365_reg;
    logic [11:0] yq_reg;
    logic [6:0]  y100_reg;
    logic [8:0]  doy_reg;
    logic [28:0] h_ms_reg, oh_ms_reg;
    logic [22:0] mi_ms_reg, om_ms_reg;
    logic [16:0] s_ms_reg;
    logic [9:0]  f_ms_reg;
    logic signed [24:0] days_reg;
    logic signed [31:0] tms_reg;
    logic signed [48:0] dms_reg;
    logic        mv_reg;
    logic [55:0] md_reg;

    logic [3:0]  dv;
    logic [11:0] lyq;
    logic [6:0]  ly100;
    logic        div4, div100, leap, mon_ok;
    logic [4:0]  dim;
    logic [3:0]  status_c;
    logic [14:0] ybig;
    logic [11:0] yq_c;
    logic [6:0]  y100_c;
    logic [9:0]  frac_c;
    logic signed [31:0] tsum, osum;
    logic signed [52:0] dprod;

    assign dv = cmd.digit;

    function automatic logic [6:0] acc2(input logic [6:0] a, input logic first,
                                        input logic [3:0] d);
        logic [10:0] t;
        t = (first ? 11'd0 : 11'(a) * 11'd10) + 11'(d);
        return t[6:0];
    endfunction

    // calendar checks on the held fields
    assign lyq    = year_reg[13:2];
    assign ly100  = 7'((24'(lyq) * 24'd2622) >> 16);
    assign div4   = (year_reg[1:0] == 2'd0);
    assign div100 = div4 && (lyq == 12'((12'(ly100) << 4) + (12'(ly100) << 3) + 12'(ly100)));
    assign leap   = div4 && (!div100 || (ly100[1:0] == 2'd0));
    assign mon_ok = (month_reg >= 7'd1) && (month_reg <= 7'd12);
    assign dim    = tte_pkg::month_days(month_reg[3:0], leap);

    always_comb begin
        if (!cmd.parse_ok)                             status_c = tte_pkg::ST_SYNTAX;
        else if (!mon_ok)                              status_c = tte_pkg::ST_MONTH;
        else if (day_reg < 7'd1 || day_reg > 7'(dim))  status_c = tte_pkg::ST_DAY;
        else if (hour_reg > 7'd23)                     status_c = tte_pkg::ST_HOUR;
        else if (min_reg > 7'd59)                      status_c = tte_pkg::ST_MINUTE;
        else if (sec_reg > ((min_reg == 7'd59) ? 7'd60 : 7'd59))
                                                       status_c = tte_pkg::ST_SECOND;
        else if (offh_reg > 7'd23)                     status_c = tte_pkg::ST_OFFHOUR;
        else if (offm_reg > 7'd59)                     status_c = tte_pkg::ST_OFFMIN;
        else                                           status_c = tte_pkg::ST_OK;
    end

    // shift the year by one 400-year era so every term stays non-negative
    assign ybig   = 15'(year_reg) + 15'd400 - ((month_reg <= 7'd2) ? 15'd1 : 15'd0);
    assign yq_c   = ybig[13:2];
    assign y100_c = 7'((24'(yq_c) * 24'd2622) >> 16);
    assign frac_c = (fd_reg == 2'd1) ? 10'(millis_reg * 10'd100) :
                    (fd_reg == 2'd2) ? 10'(millis_reg * 10'd10) : millis_reg;

    assign tsum = $signed({3'b0, h_ms_reg}) + $signed({9'b0, mi_ms_reg}) +
                  $signed({15'b0, s_ms_reg}) + $signed({22'b0, f_ms_reg});
    assign osum = $signed({3'b0, oh_ms_reg}) + $signed({9'b0, om_ms_reg});
    assign dprod = days_reg * $signed(28'sd86400000);

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.calc1) begin
            year_reg   <= '0;
            month_reg  <= 7'd1;
            day_reg    <= 7'd1;
            hour_reg   <= '0;
            min_reg    <= '0;
            sec_reg    <= '0;
            millis_reg <= '0;
            fd_reg     <= '0;
            sign_reg   <= '0;
            offh_reg   <= '0;
            offm_reg   <= '0;
        end else begin
            if (cmd.ld_year)
                year_reg <= 14'((cmd.first_digit ? 18'd0 : 18'(year_reg) * 18'd10) + 18'(dv));
            if (cmd.ld_month) month_reg <= acc2(month_reg, cmd.first_digit, dv);
            if (cmd.ld_day)   day_reg   <= acc2(day_reg, cmd.first_digit, dv);
            if (cmd.ld_hour)  hour_reg  <= acc2(hour_reg, 1'b0, dv);
            if (cmd.ld_min)   min_reg   <= acc2(min_reg, 1'b0, dv);
            if (cmd.ld_sec)   sec_reg   <= acc2(sec_reg, 1'b0, dv);
            if (cmd.ld_offh)  offh_reg  <= acc2(offh_reg, 1'b0, dv);
            if (cmd.ld_offm)  offm_reg  <= acc2(offm_reg, 1'b0, dv);
            if (cmd.ld_frac && fd_reg != 2'd3) begin
                millis_reg <= 10'(millis_reg * 10'd10 + 10'(dv));
                fd_reg     <= fd_reg + 2'd1;
            end
            if (cmd.set_plus)  sign_reg <= 2'd1;
            if (cmd.set_minus) sign_reg <= 2'd2;
        end
        if (cmd.calc1) begin
            status_reg <= status_c;
            y365_reg   <= 22'(ybig) * 22'd365;
            yq_reg     <= yq_c;
            y100_reg   <= y100_c;
            doy_reg    <= tte_pkg::month_start(month_reg[3:0]) + 9'(day_reg) - 9'd1;
            h_ms_reg   <= 29'(hour_reg) * 29'd3600000;
            mi_ms_reg  <= 23'(min_reg) * 23'd60000;
            s_ms_reg   <= 17'(sec_reg) * 17'd1000;
            f_ms_reg   <= frac_c;
            oh_ms_reg  <= 29'(offh_reg) * 29'd3600000;
            om_ms_reg  <= 23'(offm_reg) * 23'd60000;
            sgn_s_reg  <= sign_reg;
        end
        if (cmd.calc2) begin
            days_reg <= $signed({3'b0, y365_reg}) + $signed({13'b0, yq_reg}) -
                        $signed({18'b0, y100_reg}) + $signed({20'b0, y100_reg[6:2]}) +
                        $signed({16'b0, doy_reg}) - 25'sd865565;
            tms_reg  <= (sgn_s_reg == 2'd1) ? tsum - osum :
                        (sgn_s_reg == 2'd2) ? tsum + osum : tsum;
        end
        if (cmd.calc3)
            dms_reg <= dprod[48:0];
        if (cmd.out_load) begin
            md_reg[3:0]   <= status_reg;
            md_reg[52:4]  <= (status_reg != tte_pkg::ST_OK) ? 49'd0 :
                             49'(dms_reg + 49'(tms_reg));
            md_reg[55:53] <= 3'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_reg <= 1'b0;
        end else if (cmd.out_load) begin
            mv_reg <= 1'b1;
        end else if (m_tready) begin
            mv_reg <= 1'b0;
        end
    end

    assign stat.out_free = !mv_reg || m_tready;
    assign m_tvalid      = mv_reg;
    assign m_tdata       = md_reg;
endmodule
`default_nettype wire

/* design/timestamp_text_to_epoch_ms.sv */
// Streaming timestamp text parser that yields epoch milliseconds.
// Usage:
//   Feed the timestamp text on the s_ channel, one character per beat, with
//   s_tlast high on the final character. Characters are taken one per cycle
//   while s_tready is high. After the final character the parser runs the
//   date arithmetic steps with s_tready low (checks and era split, day sum,
//   day-to-millisecond multiply, final add); the result beat then appears
//   on m_ with status in bits 3:0 and epoch milliseconds in bits 52:4.
//   A result that is not taken holds in the output register; the parser then
//   holds in the last arithmetic step with s_tready low, so the next string
//   waits until the output register frees up.
//   Reset (aresetn low, synchronous) drops any result and partial parse.
`default_nettype none
module timestamp_text_to_epoch_ms (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // char_byte
    input  wire logic        s_tlast,   // last_char
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata    // status[3:0], epoch_ms[52:4], zero pad
);
    tte_pkg::tte_cmd_t  cmd;
    tte_pkg::tte_stat_t stat;

    tte_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .cmd(cmd), .stat(stat)
    );

    tte_dpath u_dpath (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );
endmodule
`default_nettype wire

/* design/tte_checker.sv */
// Port-level checks of the timestamp parser and their binding.
`default_nettype none
`include "timestamp_text_to_epoch_ms_macros.svh"
module tte_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        s_tlast,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [55:0] m_tdata
);
    `TTE_ASSERT_NEXT(a_hold, !aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `TTE_ASSERT_NOW(a_code, !aresetn, m_tvalid, m_tdata[3:0] <= tte_pkg::ST_OFFMIN)
    `TTE_ASSERT_NOW(a_errz, !aresetn, m_tvalid && m_tdata[3:0] != tte_pkg::ST_OK, m_tdata[52:4] == 49'd0)
    `TTE_ASSERT_NEXT(a_busy, !aresetn, s_tvalid && s_tready && s_tlast, !s_tready)
endmodule
bind timestamp_text_to_epoch_ms tte_checker u_tte_checker (.*);
`default_nettype wire
